### sv/spectrum_power_integrator_unit_macros.svh
// assertion macros used by the checker file
`ifndef SPECTRUM_POWER_INTEGRATOR_UNIT_MACROS_SVH
`define SPECTRUM_POWER_INTEGRATOR_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define SPI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spi assertion failed");

// next-cycle implication, off while reset is high
`define SPI_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spi assertion failed");

// next-cycle implication that also watches reset itself
`define SPI_ASSERT_NXT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("spi assertion failed");

`endif

### sv/spi_pkg.sv
// shared constants and types of the spectrum power integrator
package spi_pkg;

   localparam int BINS         = 1024;
   localparam int BIN_W        = $clog2(BINS);
   localparam int SAMPLE_WIDTH = 16;
   localparam int ACC_WIDTH    = 48;
   localparam int DIV_W        = 32;
   localparam int SCALE_SHIFT  = $clog2(BINS);
   localparam int SQ_W         = 2 * SAMPLE_WIDTH;
   localparam int PWR_W        = SQ_W - SCALE_SHIFT;
   localparam int DIV_CNT_W    = $clog2(ACC_WIDTH);
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

   // command codes
   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_READ       = 1'b1;

   // register indexes, taken from paddr bit 2
   localparam logic REG_DIVISOR   = 1'b0;
   localparam logic REG_CENTER_DC = 1'b1;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } spi_div_status_type;

endpackage

### sv/spi_ram.sv
// generic single-write single-read ram with registered read data
module spi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/spi_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module spi_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [spi_pkg::ACC_WIDTH-1:0]       dividend,
   input  logic [spi_pkg::DIV_W-1:0]           divisor,
   input  logic                                take,
   output spi_pkg::spi_div_status_type         status,
   output logic [spi_pkg::ACC_WIDTH-1:0]       quotient
);

   import spi_pkg::*;

   div_state_type          state_ff, state_in;
   logic [ACC_WIDTH-1:0]   work_ff, work_in;
   logic [DIV_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       dvs_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W:0]         trial;
   logic                   fits;
   logic                   step_en;
   logic                   last_step;

   assign last_step = (cnt_ff == DIV_CNT_W'(ACC_WIDTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_RUN;
         DIV_RUN:  if (last_step) state_in = DIV_DONE;
         DIV_DONE: if (take) state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      status.busy = 1'b0;
      status.done = 1'b0;
      step_en     = 1'b0;
      case (state_ff)
         DIV_IDLE: ;
         DIV_RUN: begin
            status.busy = 1'b1;
            step_en     = 1'b1;
         end
         DIV_DONE: begin
            status.busy = 1'b1;
            status.done = 1'b1;
         end
         default: ;
      endcase
   end

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, work_ff[ACC_WIDTH-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      rem_in  = fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
      work_in = {work_ff[ACC_WIDTH-2:0], fits};
      cnt_in  = cnt_ff + DIV_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && (state_ff == DIV_IDLE)) begin
         work_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         cnt_ff  <= '0;
      end else if (step_en) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign quotient = work_ff;

endmodule

### sv/spectrum_power_integrator_unit.sv
// top level of the per-bin spectrum power integrator
//
// usage
// - req channel: command 0 adds (re*re + im*im) >> log2(bins) to the bin's
//   48-bit accumulator, saturating at all ones; with center_dc set the bin
//   address has its top bit flipped (fft shift). command 1 reads a bin,
//   clears it and returns accumulator / integration_divisor on rsp
// - accumulate transfers are taken one per cycle, back to back, while req_ready
//   is high (no sweep or read holds it low), with no result; a read-modify-write of
//   the same bin in consecutive cycles is forwarded from the write register
// - a read transfer goes through the ram read that loads the divider, the
//   divider (one quotient bit per step) and a handover to rsp; req_ready stays
//   low until the handover, so a new read waits until the last leaves the divider
// - a finished result waits in the rsp register; accumulates keep flowing and a
//   second read still enters the divider, but its quotient then waits and
//   req_ready stays low until the receiver takes the first result
// - after reset the accumulator ram is zeroed by a sweep over all 1024 bins with
//   req_ready low; csr writes are taken during the sweep
// - csr: divisor at byte 0 (0 acts as 1), center_dc at byte 4, pready high
module spectrum_power_integrator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_command,
   input  logic [spi_pkg::BIN_W-1:0]              req_bin_index,
   input  logic signed [spi_pkg::SAMPLE_WIDTH-1:0] req_real_part,
   input  logic signed [spi_pkg::SAMPLE_WIDTH-1:0] req_imag_part,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [spi_pkg::BIN_W-1:0]              rsp_out_bin,
   output logic [spi_pkg::ACC_WIDTH-1:0]          rsp_integrated_power,
   output logic                                   rsp_saturated,
   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [spi_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [spi_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [spi_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   import spi_pkg::*;

   // configuration registers
   logic [DIV_W-1:0]       divisor_ff, divisor_in;
   logic                   center_ff, center_in;
   logic                   csr_wr;
   logic                   csr_idx;

   // clearing sweep
   logic                   clearing_ff, clearing_in;
   logic [BIN_W-1:0]       clr_cnt_ff, clr_cnt_in;

   // accept stage
   logic                   accept;
   logic [BIN_W-1:0]       acc_addr;
   logic [BIN_W-1:0]       rd_addr;
   logic signed [SQ_W-1:0] sq_re;
   logic signed [SQ_W-1:0] sq_im;
   logic [SQ_W-1:0]        sq_sum;

   // ram-data stage
   logic                   pipe_valid_ff;
   logic                   pipe_cmd_ff;
   logic [BIN_W-1:0]       pipe_addr_ff;
   logic [PWR_W-1:0]       pipe_pwr_ff;
   logic [ACC_WIDTH-1:0]   ram_rd_data;
   logic [ACC_WIDTH-1:0]   base;
   logic [ACC_WIDTH:0]     sum_wide;
   logic [ACC_WIDTH-1:0]   acc_new;
   logic                   read_in_pipe;

   // ram write side and forwarding of the last write
   logic                   wr_en;
   logic [BIN_W-1:0]       wr_addr;
   logic [ACC_WIDTH-1:0]   wr_data;
   logic                   fwd_valid_ff;
   logic [BIN_W-1:0]       fwd_addr_ff;
   logic [ACC_WIDTH-1:0]   fwd_data_ff;

   // divider and result
   spi_div_status_type     div_status;
   logic                   div_start;
   logic                   div_take;
   logic [DIV_W-1:0]       div_divisor;
   logic [ACC_WIDTH-1:0]   div_quotient;
   logic [BIN_W-1:0]       pend_bin_ff;
   logic                   pend_sat_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]       rsp_bin_ff;
   logic [ACC_WIDTH-1:0]   rsp_power_ff;
   logic                   rsp_sat_ff;

   // ---------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      divisor_in = divisor_ff;
      center_in  = center_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_DIVISOR:   divisor_in = csr_pwdata[DIV_W-1:0];
            REG_CENTER_DC: center_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DIVISOR:   csr_prdata = CSR_DATA_W'(divisor_ff);
         REG_CENTER_DC: csr_prdata = CSR_DATA_W'(center_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= DIV_W'(1);
         center_ff  <= 1'b1;
      end else begin
         divisor_ff <= divisor_in;
         center_ff  <= center_in;
      end
   end

   // ---------------------------------------------------------------
   // post-reset sweep that zeroes every bin
   // ---------------------------------------------------------------
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + BIN_W'(1);
         if (clr_cnt_ff == BIN_W'(BINS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // ---------------------------------------------------------------
   // accept stage: address, ram read issue, power of the sample
   // ---------------------------------------------------------------
   // a read in the data stage or in the divider holds off the next transfer
   assign read_in_pipe = pipe_valid_ff && (pipe_cmd_ff == CMD_READ);
   assign req_ready    = !clearing_ff && !div_status.busy && !read_in_pipe;
   assign accept       = req_valid && req_ready;

   // fft shift: adding bins/2 modulo bins flips the top address bit
   assign acc_addr = center_ff ? {~req_bin_index[BIN_W-1], req_bin_index[BIN_W-2:0]}
                               : req_bin_index;
   assign rd_addr  = (req_command == CMD_READ) ? req_bin_index : acc_addr;

   assign sq_re  = SQ_W'(req_real_part) * SQ_W'(req_real_part);
   assign sq_im  = SQ_W'(req_imag_part) * SQ_W'(req_imag_part);
   // both squares are non-negative, their sum fits the unsigned width
   assign sq_sum = $unsigned(sq_re) + $unsigned(sq_im);

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pipe_cmd_ff  <= req_command;
         pipe_addr_ff <= rd_addr;
         pipe_pwr_ff  <= sq_sum[SQ_W-1:SCALE_SHIFT];
      end
   end

   spi_ram #(
      .WIDTH (ACC_WIDTH),
      .DEPTH (BINS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // data stage: saturating add or read-and-clear, write back
   // ---------------------------------------------------------------
   // the write at the edge of our ram read is not in the read data yet
   assign base = (fwd_valid_ff && (fwd_addr_ff == pipe_addr_ff)) ? fwd_data_ff
                                                                 : ram_rd_data;
   assign sum_wide = {1'b0, base} + (ACC_WIDTH + 1)'(pipe_pwr_ff);
   assign acc_new  = sum_wide[ACC_WIDTH] ? ACC_MAX : sum_wide[ACC_WIDTH-1:0];

   always_comb begin
      wr_en   = clearing_ff || pipe_valid_ff;
      wr_addr = clearing_ff ? clr_cnt_ff : pipe_addr_ff;
      if (clearing_ff || (pipe_cmd_ff == CMD_READ)) begin
         wr_data = '0;
      end else begin
         wr_data = acc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   // ---------------------------------------------------------------
   // readout: divide, then hand over to the rsp register
   // ---------------------------------------------------------------
   assign div_start   = read_in_pipe;
   assign div_divisor = (divisor_ff == '0) ? DIV_W'(1) : divisor_ff;
   assign div_take    = div_status.done && (!rsp_valid_ff || rsp_ready);

   spi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (base),
      .divisor  (div_divisor),
      .take     (div_take),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (div_start) begin
         pend_bin_ff <= pipe_addr_ff;
         pend_sat_ff <= (base == ACC_MAX);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (div_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_take) begin
         rsp_bin_ff   <= pend_bin_ff;
         rsp_power_ff <= div_quotient;
         rsp_sat_ff   <= pend_sat_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_bin          = rsp_bin_ff;
   assign rsp_integrated_power = rsp_power_ff;
   assign rsp_saturated        = rsp_sat_ff;

endmodule

### sv/spi_checker.sv
// port-level checker for the spectrum power integrator, bound to the top level
`include "spectrum_power_integrator_unit_macros.svh"

module spi_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   req_command,
   input  logic [spi_pkg::BIN_W-1:0]              req_bin_index,
   input  logic signed [spi_pkg::SAMPLE_WIDTH-1:0] req_real_part,
   input  logic signed [spi_pkg::SAMPLE_WIDTH-1:0] req_imag_part,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [spi_pkg::BIN_W-1:0]              rsp_out_bin,
   input  logic [spi_pkg::ACC_WIDTH-1:0]          rsp_integrated_power,
   input  logic                                   rsp_saturated,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [spi_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [spi_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   input  logic [spi_pkg::CSR_DATA_W-1:0]         csr_prdata,
   input  logic                                   csr_pready
);

   import spi_pkg::*;

   // stalled response holds its payload
   `SPI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_integrated_power) && $stable(rsp_out_bin) && $stable(rsp_saturated))

   // the clearing sweep keeps the request side closed after reset
   `SPI_ASSERT_NXT_RST(a_clear_after_reset, reset, !req_ready)

   // an accepted read blocks the next cycle while it reaches the divider
   `SPI_ASSERT_NXT(a_read_blocks, req_valid && req_ready && (req_command == CMD_READ), !req_ready)

   // a saturated bin over any 32-bit divisor never yields zero
   `SPI_ASSERT_IMP(a_sat_nonzero, rsp_valid && rsp_saturated, rsp_integrated_power != '0)

endmodule

bind spectrum_power_integrator_unit spi_checker u_spi_checker (.*);

### tb/tb_spectrum_power_integrator_unit.sv
// self-checking testbench for the per-bin spectrum power integrator
`timescale 1ns / 100ps

module tb_spectrum_power_integrator_unit;

   localparam int BINS         = spi_pkg::BINS;
   localparam int BIN_W        = spi_pkg::BIN_W;
   localparam int SAMPLE_WIDTH = spi_pkg::SAMPLE_WIDTH;
   localparam int ACC_WIDTH    = spi_pkg::ACC_WIDTH;
   localparam int SCALE_SHIFT  = spi_pkg::SCALE_SHIFT;
   localparam int DATA_W       = spi_pkg::CSR_DATA_W;

   // run shape
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 115;
   localparam int RSP_HOLD_CYCLES = 400;
   // accumulate pipeline depth guess, plus margin, before touching registers
   localparam int PIPE_DRAIN      = 8;
   // a read passes through the divider before its response, so watch this long for stray transfers at the end
   localparam int END_DRAIN       = 64;
   // covers the clearing sweep over all bins, the long receiver hold and a divide
   localparam int STALL_LIMIT     = 4000;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [BIN_W-1:0] HALF_BINS = BIN_W'(BINS / 2);
   localparam logic [63:0] ACC_MAX64 = 64'(spi_pkg::ACC_MAX);

   // one readout as the rsp channel should deliver it
   typedef struct {
      logic [BIN_W-1:0]     bin;
      logic [ACC_WIDTH-1:0] power;
      logic                 sat;
   } readout_type;

   // dut ports
   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_command;
   logic [BIN_W-1:0]           req_bin_index;
   sample_type                 req_real_part;
   sample_type                 req_imag_part;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [BIN_W-1:0]           rsp_out_bin;
   logic [ACC_WIDTH-1:0]       rsp_integrated_power;
   logic                       rsp_saturated;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [spi_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0]          csr_pwdata;
   logic [DATA_W-1:0]          csr_prdata;
   logic                       csr_pready;

   // predictor state: accumulators and register copies
   logic [ACC_WIDTH-1:0] bin_power_model [BINS];
   logic [31:0]          divisor_model;
   logic                 center_model;

   // readouts predicted but not yet seen on rsp, oldest first
   readout_type readouts_due [$];

   int  errors;
   int  items_sent;
   // both sides insert random idle cycles while this is set
   bit  idle_on;
   // asks the rsp side to hold off for RSP_HOLD_CYCLES
   bit  rsp_hold_request;

   spectrum_power_integrator_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_bin_index        (req_bin_index),
      .req_real_part        (req_real_part),
      .req_imag_part        (req_imag_part),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_bin          (rsp_out_bin),
      .rsp_integrated_power (rsp_integrated_power),
      .rsp_saturated        (rsp_saturated),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor: applies one accepted request to the model, queues a readout for reads
   function automatic void integrate_model(input logic cmd, input logic [BIN_W-1:0] bin,
                                           input sample_type re, input sample_type im);
      logic [BIN_W-1:0] addr;
      longint           re_l;
      longint           im_l;
      logic [63:0]      power;
      logic [63:0]      acc;
      readout_type      r;
      if (cmd == spi_pkg::CMD_ACCUMULATE) begin
         // fft shift: with centering on, flip the top address bit
         addr  = center_model ? (bin ^ HALF_BINS) : bin;
         re_l  = re;
         im_l  = im;
         power = 64'(re_l * re_l + im_l * im_l) >> SCALE_SHIFT;
         acc   = 64'(bin_power_model[addr]);
         // clamp at all ones instead of wrapping
         if (power > ACC_MAX64 - acc)
            bin_power_model[addr] = spi_pkg::ACC_MAX;
         else
            bin_power_model[addr] = ACC_WIDTH'(acc + power);
      end else begin
         // reads use the address as given, never shifted
         acc     = 64'(bin_power_model[bin]);
         r.bin   = bin;
         r.sat   = (bin_power_model[bin] == spi_pkg::ACC_MAX);
         // a zero divisor acts as one
         r.power = ACC_WIDTH'(acc / ((divisor_model == 0) ? 64'd1 : 64'(divisor_model)));
         bin_power_model[bin] = '0;
         readouts_due.push_back(r);
      end
   endfunction

   // mostly random samples, with the full-scale and near-zero values mixed in
   function automatic sample_type rand_sample();
      case ($urandom_range(0, 19))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2:       return '0;
         3:       return '1;
         default: return sample_type'($urandom());
      endcase
   endfunction

   // offers one request and waits for its transfer, then updates the predictor
   task automatic send_req(input logic cmd, input logic [BIN_W-1:0] bin,
                           input sample_type re, input sample_type im);
      while (idle_on && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_bin_index <= bin;
      req_real_part <= re;
      req_imag_part <= im;
      do @(posedge clock); while (!req_ready);
      integrate_model(cmd, bin, re, im);
      items_sent++;
   endtask

   // drops valid, waits for every readout, then lets trailing accumulates retire
   task automatic settle_idle(input int pad);
      req_valid <= 1'b0;
      @(posedge clock);
      while (readouts_due.size() != 0) @(posedge clock);
      repeat (pad) @(posedge clock);
   endtask

   // register write (setup + access), then read back and compare
   task automatic write_csr(input logic reg_sel, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] readback_want;
      readback_want = (reg_sel == spi_pkg::REG_CENTER_DC) ? DATA_W'(value[0]) : value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // psel stays high: straight into the setup cycle of the read
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== readback_want) begin
         $display("%0t: register %0d readback, expected %0h, actual %0h",
                  $time, reg_sel, readback_want, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (reg_sel == spi_pkg::REG_DIVISOR)
         divisor_model = value;
      else
         center_model = value[0];
   endtask

   // the clearing sweep must leave every bin at zero; the first, last and middle bins are read
   task automatic test_cleared_after_reset();
      send_req(spi_pkg::CMD_READ, '0, '0, '0);
      send_req(spi_pkg::CMD_READ, '1, SAMPLE_MIN, SAMPLE_MAX);
      send_req(spi_pkg::CMD_READ, HALF_BINS, '1, '1);
   endtask

   // full-scale samples, successive updates of one bin, edge bins, read clears
   task automatic test_full_scale_power();
      send_req(spi_pkg::CMD_ACCUMULATE, '0, SAMPLE_MIN, SAMPLE_MIN);
      send_req(spi_pkg::CMD_ACCUMULATE, '0, SAMPLE_MIN, SAMPLE_MIN);
      send_req(spi_pkg::CMD_ACCUMULATE, '1, SAMPLE_MAX, SAMPLE_MIN);
      send_req(spi_pkg::CMD_ACCUMULATE, HALF_BINS, '1, '1);
      send_req(spi_pkg::CMD_ACCUMULATE, HALF_BINS - 1'b1, SAMPLE_MAX, SAMPLE_MAX);
      send_req(spi_pkg::CMD_READ, HALF_BINS, '0, '0);
      send_req(spi_pkg::CMD_READ, HALF_BINS - 1'b1, '0, '0);
      send_req(spi_pkg::CMD_READ, '1, '0, '0);
      send_req(spi_pkg::CMD_READ, '0, '0, '0);
      // read of a bin just cleared
      send_req(spi_pkg::CMD_READ, HALF_BINS, '0, '0);
   endtask

   // zero and all-ones divisor, centering off and on, read right behind its update
   task automatic test_divisor_and_centering();
      settle_idle(PIPE_DRAIN);
      write_csr(spi_pkg::REG_DIVISOR, '0);
      write_csr(spi_pkg::REG_CENTER_DC, '0);
      send_req(spi_pkg::CMD_ACCUMULATE, BIN_W'(5), sample_type'(1000), sample_type'(-2000));
      send_req(spi_pkg::CMD_READ, BIN_W'(5), '0, '0);
      settle_idle(PIPE_DRAIN);
      write_csr(spi_pkg::REG_DIVISOR, '1);
      send_req(spi_pkg::CMD_ACCUMULATE, BIN_W'(7), SAMPLE_MAX, SAMPLE_MAX);
      send_req(spi_pkg::CMD_READ, BIN_W'(7), '0, '0);
      settle_idle(PIPE_DRAIN);
      write_csr(spi_pkg::REG_DIVISOR, DATA_W'(3));
      write_csr(spi_pkg::REG_CENTER_DC, DATA_W'(1));
      send_req(spi_pkg::CMD_ACCUMULATE, BIN_W'(9), SAMPLE_MIN, '0);
      send_req(spi_pkg::CMD_ACCUMULATE, BIN_W'(9), sample_type'(12345),
               sample_type'(-23456));
      send_req(spi_pkg::CMD_READ, BIN_W'(9) ^ HALF_BINS, '0, '0);
   endtask

   // integration runs with random content under several register settings:
   // a cluster of bins is integrated, then read back in output order;
   // a minority of single random requests stirs in noise
   task automatic test_random_integration();
      logic [BIN_W-1:0] base;
      int               span;
      int               phase_end;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_idle(PIPE_DRAIN);
         case (phase)
            0: begin
               write_csr(spi_pkg::REG_DIVISOR, DATA_W'(1));
               write_csr(spi_pkg::REG_CENTER_DC, DATA_W'(1));
            end
            1: begin
               write_csr(spi_pkg::REG_DIVISOR, DATA_W'(3));
               write_csr(spi_pkg::REG_CENTER_DC, DATA_W'(0));
            end
            2: begin
               write_csr(spi_pkg::REG_DIVISOR, DATA_W'(1));
            end
            3: begin
               write_csr(spi_pkg::REG_DIVISOR, DATA_W'($urandom_range(2, 5000)));
               write_csr(spi_pkg::REG_CENTER_DC, DATA_W'(1));
            end
            4: begin
               write_csr(spi_pkg::REG_DIVISOR, DATA_W'($urandom()));
               write_csr(spi_pkg::REG_CENTER_DC, DATA_W'($urandom_range(0, 1)));
            end
            default: begin
               write_csr(spi_pkg::REG_DIVISOR, DATA_W'(1) << $urandom_range(0, 20));
               write_csr(spi_pkg::REG_CENTER_DC, DATA_W'($urandom_range(0, 1)));
            end
         endcase
         // phase 2 is the stretch with both sides always ready
         idle_on   = (phase != 2);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 80) begin
               base = BIN_W'($urandom());
               span = $urandom_range(1, 4);
               repeat ($urandom_range(1, 10))
                  send_req(spi_pkg::CMD_ACCUMULATE, base + BIN_W'($urandom_range(0, span - 1)),
                           rand_sample(), rand_sample());
               for (int k = 0; k < span; k++)
                  if ($urandom_range(0, 3) != 0)
                     send_req(spi_pkg::CMD_READ,
                              (base + BIN_W'(k)) ^ (center_model ? HALF_BINS : '0),
                              rand_sample(), rand_sample());
            end else begin
               send_req($urandom_range(0, 1) ? spi_pkg::CMD_READ : spi_pkg::CMD_ACCUMULATE,
                        BIN_W'($urandom()), rand_sample(), rand_sample());
            end
         end
         idle_on = 1'b1;
      end
   endtask

   // receiver holds off for a long stretch: a readout parks in the rsp register,
   // accumulates keep going, the next read has to wait at the input
   task automatic test_readout_backpressure();
      settle_idle(PIPE_DRAIN);
      rsp_hold_request = 1'b1;
      repeat (4) begin
         send_req(spi_pkg::CMD_READ, BIN_W'($urandom()), rand_sample(), rand_sample());
         repeat (24)
            send_req(spi_pkg::CMD_ACCUMULATE, BIN_W'($urandom()), rand_sample(), rand_sample());
      end
   endtask

   // rsp side: checks each transfer against the oldest prediction, then picks
   // the next ready value (random idling or a requested hold-off)
   initial begin
      readout_type due;
      int          hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (readouts_due.size() == 0) begin
               $display("%0t: readout transfer for bin %0d with none outstanding",
                        $time, rsp_out_bin);
               errors++;
            end else begin
               due = readouts_due.pop_front();
               if (rsp_out_bin !== due.bin) begin
                  $display("%0t: out_bin expected %0d, actual %0d",
                           $time, due.bin, rsp_out_bin);
                  errors++;
               end
               if (rsp_integrated_power !== due.power) begin
                  $display("%0t: integrated_power of bin %0d expected %0d, actual %0d",
                           $time, due.bin, due.power, rsp_integrated_power);
                  errors++;
               end
               if (rsp_saturated !== due.sat) begin
                  $display("%0t: saturated of bin %0d expected %0b, actual %0b",
                           $time, due.bin, due.sat, rsp_saturated);
                  errors++;
               end
            end
         end
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left        = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(0, 99) < 20);
         end
      end
   end

   // watchdog: too many cycles without any transfer ends the run
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   // main sequence
   initial begin
      errors           = 0;
      items_sent       = 0;
      idle_on          = 1'b1;
      rsp_hold_request = 1'b0;
      // model matches the state after reset
      for (int i = 0; i < BINS; i++)
         bin_power_model[i] = '0;
      divisor_model = 32'd1;
      center_model  = 1'b1;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_command   <= spi_pkg::CMD_ACCUMULATE;
      req_bin_index <= '0;
      req_real_part <= '0;
      req_imag_part <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // saturation needs ~2^27 full-scale samples into one bin, out of reach here;
      // the saturated flag is still checked on every readout
      test_cleared_after_reset();
      test_full_scale_power();
      test_divisor_and_centering();
      test_random_integration();
      test_readout_backpressure();

      settle_idle(END_DRAIN);
      if (errors == 0 && readouts_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
